// ===== rtl/prtm_pkg.sv =====
// Shared types, codes and helpers for the prefix route table.
// Depends on nothing; every other file of the block imports it.
package prtm_pkg;

	localparam int ENTRIES_DEFAULT = 64;
	localparam int ADDR_W = 32;
	localparam int PLEN_W = 6;

	typedef enum logic [1:0] {
		ACT_SET        = 2'd0,
		ACT_DELETE     = 2'd1,
		ACT_LOOKUP_DST = 2'd2,
		ACT_LOOKUP_HOP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] network;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
	} entry_t;

	function automatic logic [ADDR_W-1:0] make_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen == '0) begin
			m = '0;
		end else if (plen >= PLEN_W'(ADDR_W)) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - plen);
		end
		return m;
	endfunction

endpackage

// ===== rtl/prtm_req_if.sv =====
// Request channel of the route table: valid/ready with one operation per beat.
// Depends on prtm_pkg for the action code type.
interface prtm_req_if;
	import prtm_pkg::*;

	logic                valid;
	logic                ready;
	action_t             action;
	logic [ADDR_W-1:0]   net_addr;
	logic [PLEN_W-1:0]   pfx_len;
	logic [ADDR_W-1:0]   hop_addr;

	modport source (output valid, action, net_addr, pfx_len, hop_addr, input ready);
	modport sink (input valid, action, net_addr, pfx_len, hop_addr, output ready);
endinterface

// ===== rtl/prtm_rsp_if.sv =====
// Response channel of the route table: valid/ready with one result per beat.
// Depends on prtm_pkg for the status code type.
interface prtm_rsp_if;
	import prtm_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [ADDR_W-1:0] found_addr;

	modport source (output valid, status, found_addr, input ready);
	modport sink (input valid, status, found_addr, output ready);
endinterface

// ===== rtl/prtm_table_mem.sv =====
// Entry storage of the route table: one write port, one read port, registered read data.
// Depends on prtm_pkg for the entry type.
module prtm_table_mem #(
	parameter int ENTRIES = prtm_pkg::ENTRIES_DEFAULT,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output prtm_pkg::entry_t      rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  prtm_pkg::entry_t      wr_data
);
	import prtm_pkg::*;

	entry_t mem_q [ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== rtl/prtm_ctrl.sv =====
// Sequencer of the route table: scans the entry memory, then updates or swaps entries.
// Depends on prtm_pkg and on the request and response interfaces.
module prtm_ctrl #(
	parameter int ENTRIES = prtm_pkg::ENTRIES_DEFAULT,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	prtm_req_if.sink             req,
	prtm_rsp_if.source           rsp,
	output logic                 rd_en,
	output logic [IDX_W-1:0]     rd_addr,
	input  prtm_pkg::entry_t     rd_data,
	output logic                 wr_en,
	output logic [IDX_W-1:0]     wr_addr,
	output prtm_pkg::entry_t     wr_data
);
	import prtm_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEL_WR,
		ST_SWAP_FRONT,
		ST_SWAP_HIT,
		ST_MISS,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  hit_idx_q;
	entry_t            hit_q;
	action_t           act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] mask_q;
	logic [ADDR_W-1:0] hop_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_found_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [ADDR_W-1:0] rsp_found_q;

	logic              match;
	logic              last;
	logic              full;
	logic [IDX_W-1:0]  last_idx;
	entry_t            new_entry;

	assign last      = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;
	assign full      = count_q == CNT_W'(ENTRIES);
	assign last_idx  = IDX_W'(count_q - CNT_W'(1));
	assign new_entry = '{network: addr_q & mask_q, mask: mask_q, hop: hop_q};

	always_comb begin
		unique case (act_q)
			ACT_SET, ACT_DELETE: match = (rd_data.network == (addr_q & mask_q)) &&
				(rd_data.mask == mask_q);
			ACT_LOOKUP_DST: match = (addr_q & rd_data.mask) == rd_data.network;
			ACT_LOOKUP_HOP: match = rd_data.hop == hop_q;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_entry;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = req.valid;
			end
			ST_SCAN: begin
				if (match) begin
					unique case (act_q)
						ACT_SET: begin
							wr_en   = 1'b1;
							wr_addr = rd_idx_q;
						end
						ACT_DELETE: begin
							rd_en   = 1'b1;
							rd_addr = last_idx;
						end
						ACT_LOOKUP_DST, ACT_LOOKUP_HOP: begin
							rd_en = 1'b1;
						end
					endcase
				end else if (!last) begin
					rd_en   = 1'b1;
					rd_addr = rd_idx_q + IDX_W'(1);
				end
			end
			ST_DEL_WR, ST_SWAP_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = hit_idx_q;
				wr_data = rd_data;
			end
			ST_SWAP_HIT: begin
				wr_en   = 1'b1;
				wr_data = hit_q;
			end
			ST_MISS: begin
				if (act_q == ACT_SET && !full) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(count_q);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign req.ready      = state_q == ST_IDLE;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.found_addr = rsp_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			act_q       <= ACT_SET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_addr;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						act_q   <= req.action;
						addr_q  <= req.net_addr;
						mask_q  <= make_mask(req.pfx_len);
						hop_q   <= req.hop_addr;
						state_q <= (count_q == '0) ? ST_MISS : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						res_status_q <= STATUS_OK;
						hit_idx_q    <= rd_idx_q;
						hit_q        <= rd_data;
						unique case (act_q)
							ACT_SET: begin
								res_found_q <= '0;
								state_q     <= ST_DONE;
							end
							ACT_DELETE: begin
								res_found_q <= '0;
								state_q     <= ST_DEL_WR;
							end
							ACT_LOOKUP_DST: begin
								res_found_q <= rd_data.hop;
								state_q     <= (rd_idx_q == '0) ? ST_DONE : ST_SWAP_FRONT;
							end
							ACT_LOOKUP_HOP: begin
								res_found_q <= rd_data.network;
								state_q     <= (rd_idx_q == '0) ? ST_DONE : ST_SWAP_FRONT;
							end
						endcase
					end else if (last) begin
						state_q <= ST_MISS;
					end
				end
				ST_DEL_WR: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_SWAP_FRONT: begin
					state_q <= ST_SWAP_HIT;
				end
				ST_SWAP_HIT: begin
					state_q <= ST_DONE;
				end
				ST_MISS: begin
					res_found_q <= '0;
					if (act_q == ACT_SET) begin
						if (full) begin
							res_status_q <= STATUS_FULL;
						end else begin
							res_status_q <= STATUS_OK;
							count_q      <= count_q + CNT_W'(1);
						end
					end else begin
						res_status_q <= STATUS_NOT_FOUND;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_found_q  <= res_found_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count exceeds table depth");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !match) |-> !wr_en)
		else $error("memory written while scanning");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> CNT_W'(rd_idx_q) < count_q)
		else $error("scan read beyond valid entries");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q != ST_IDLE)
		else $error("accepted beat did not start an operation");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			($past(state_q) == ST_MISS || $past(state_q) == ST_DEL_WR))
		else $error("entry count changed outside append or delete");
endmodule

// ===== rtl/prefix_route_table_mtf_top.sv =====
// Top level of the prefix route table with move-to-front lookups.
// Depends on prtm_pkg, prtm_req_if, prtm_rsp_if, prtm_table_mem and prtm_ctrl.
//
// Usage: each request beat on req carries an action (set, delete, lookup by
// destination, lookup by next hop), an address, a prefix length and a hop.
// Each request produces exactly one response beat on rsp with a status and
// an address. Requests are served one at a time: req.ready is high only
// while no operation is in progress.
// The entries are read from the table memory one per cycle in table
// order. The next request can be accepted in the cycle after the response
// is loaded; the single read port of the memory bounds the scan.
// The response sits in an output register, so a new request is accepted
// while the previous response still waits; a stalled receiver holds the
// response and the next one waits in the sequencer until it is taken.
// Reset clears the entry count and the handshake state; the table memory is
// not cleared, since only entries below the count are ever used.
module prefix_route_table_mtf_top #(
	parameter int ENTRIES = prtm_pkg::ENTRIES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	prtm_req_if.sink    req,
	prtm_rsp_if.source  rsp
);
	import prtm_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	prtm_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	prtm_table_mem #(
		.ENTRIES (ENTRIES)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for prefix_route_table_mtf_top: a directed table, then random route traffic.
// Each response is checked against its typed row or an in-bench model of the table with move-to-front.
// Depends on prtm_pkg, prtm_req_if, prtm_rsp_if and the top level of the block.
module testbench;
	import prtm_pkg::*;

	localparam int TABLE_SIZE = ENTRIES_DEFAULT;
	localparam int DIR_ROWS = 22;
	localparam int IDLE_PCT = 26;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		action_t           action;
		logic [ADDR_W-1:0] net_addr;
		logic [PLEN_W-1:0] pfx_len;
		logic [ADDR_W-1:0] hop_addr;
		logic              typed;
		status_t           exp_status;
		logic [ADDR_W-1:0] exp_found;
	} route_req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] found_addr;
	} route_rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] net;
		logic [PLEN_W-1:0] plen;
	} route_key_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prtm_req_if req ();
	prtm_rsp_if rsp ();

	prefix_route_table_mtf_top #(.ENTRIES(TABLE_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [ADDR_W-1:0] tbl_net [TABLE_SIZE];
	logic [ADDR_W-1:0] tbl_mask [TABLE_SIZE];
	logic [ADDR_W-1:0] tbl_hop [TABLE_SIZE];
	int tbl_count = 0;

	route_req_t stim_q [$];
	route_rsp_t expected_rsp_q [$];
	route_key_t net_pool [$];
	logic [ADDR_W-1:0] hop_pool [8];

	route_req_t cur_req;
	route_rsp_t model_rsp;
	route_rsp_t want_rsp;
	int beats_in = 0;
	int error_count = 0;
	int stall_cycles = 0;
	bit steady;

	route_req_t dir_tab [DIR_ROWS] = '{
		'{ACT_LOOKUP_DST, 32'h0000_0000, 6'd0, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 32'h0},
		'{ACT_LOOKUP_HOP, 32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 32'h0},
		'{ACT_DELETE, 32'h0000_0000, 6'd0, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 32'h0},
		'{ACT_SET, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_DST, 32'h1234_5678, 6'd0, 32'h0000_0000, 1'b1, STATUS_OK, 32'hFFFF_FFFF},
		'{ACT_SET, 32'hFFFF_FFFF, 6'd32, 32'h0A00_0001, 1'b1, STATUS_OK, 32'h0},
		'{ACT_SET, 32'hC0A8_0155, 6'd24, 32'h0A00_0002, 1'b1, STATUS_OK, 32'h0},
		'{ACT_SET, 32'hC0A8_0177, 6'd63, 32'h0A00_0004, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_DST, 32'hC0A8_0177, 6'd0, 32'h0000_0000, 1'b1, STATUS_OK, 32'hFFFF_FFFF},
		'{ACT_LOOKUP_HOP, 32'h0000_0000, 6'd0, 32'h0A00_0002, 1'b1, STATUS_OK, 32'hC0A8_0100},
		'{ACT_LOOKUP_DST, 32'hC0A8_01FE, 6'd0, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0},
		'{ACT_SET, 32'hC0A8_01AA, 6'd24, 32'h0A00_0003, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_HOP, 32'h0000_0000, 6'd0, 32'h0A00_0002, 1'b0, STATUS_OK, 32'h0},
		'{ACT_DELETE, 32'h7FFF_FFFF, 6'd0, 32'h0000_0000, 1'b1, STATUS_OK, 32'h0},
		'{ACT_DELETE, 32'h0000_0000, 6'd0, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND, 32'h0},
		'{ACT_DELETE, 32'hC0A8_0177, 6'd33, 32'h0000_0000, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_DST, 32'hFFFF_FFFF, 6'd0, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0},
		'{ACT_SET, 32'hFFFF_FFFF, 6'd1, 32'h0000_0000, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_HOP, 32'h0000_0000, 6'd0, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_DST, 32'h7FFF_FFFF, 6'd0, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0},
		'{ACT_SET, 32'hFFFF_FFFF, 6'd40, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'h0},
		'{ACT_LOOKUP_HOP, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 1'b0, STATUS_OK, 32'h0}
	};

	function automatic logic [ADDR_W-1:0] prefix_mask(logic [PLEN_W-1:0] plen);
		if (plen == 0) begin
			return '0;
		end
		if (plen >= 32) begin
			return '1;
		end
		return 32'hFFFF_FFFF << (32 - plen);
	endfunction

	task automatic move_to_front(int idx);
		logic [ADDR_W-1:0] t;
		t = tbl_net[idx];  tbl_net[idx] = tbl_net[0];   tbl_net[0] = t;
		t = tbl_mask[idx]; tbl_mask[idx] = tbl_mask[0]; tbl_mask[0] = t;
		t = tbl_hop[idx];  tbl_hop[idx] = tbl_hop[0];   tbl_hop[0] = t;
	endtask

	task automatic route_table_step(input route_req_t r, output route_rsp_t result);
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] net;
		int hit;
		mask = prefix_mask(r.pfx_len);
		net = r.net_addr & mask;
		result.status = STATUS_NOT_FOUND;
		result.found_addr = '0;
		hit = -1;
		case (r.action)
			ACT_SET: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (hit < 0 && tbl_net[i] == net && tbl_mask[i] == mask) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					tbl_hop[hit] = r.hop_addr;
					result.status = STATUS_OK;
				end else if (tbl_count >= TABLE_SIZE) begin
					result.status = STATUS_FULL;
				end else begin
					tbl_net[tbl_count] = net;
					tbl_mask[tbl_count] = mask;
					tbl_hop[tbl_count] = r.hop_addr;
					tbl_count++;
					result.status = STATUS_OK;
				end
			end
			ACT_DELETE: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (hit < 0 && tbl_net[i] == net && tbl_mask[i] == mask) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					tbl_net[hit] = tbl_net[tbl_count-1];
					tbl_mask[hit] = tbl_mask[tbl_count-1];
					tbl_hop[hit] = tbl_hop[tbl_count-1];
					tbl_count--;
					result.status = STATUS_OK;
				end
			end
			ACT_LOOKUP_DST: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (hit < 0 && (r.net_addr & tbl_mask[i]) == tbl_net[i]) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					move_to_front(hit);
					result.status = STATUS_OK;
					result.found_addr = tbl_hop[0];
				end
			end
			ACT_LOOKUP_HOP: begin
				for (int i = 0; i < tbl_count; i++) begin
					if (hit < 0 && tbl_hop[i] == r.hop_addr) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					move_to_front(hit);
					result.status = STATUS_OK;
					result.found_addr = tbl_net[0];
				end
			end
		endcase
	endtask

	// Aims a request at a known route, with random bits below the prefix.
	function automatic route_req_t aim_at_route(route_req_t r, route_key_t k);
		r.net_addr = k.net ^ ($urandom() & ~prefix_mask(k.plen));
		r.pfx_len = (k.plen == 32) ? PLEN_W'(32 + $urandom_range(31)) : k.plen;
		return r;
	endfunction

	function automatic route_req_t random_route_op(int set_pct, int del_pct, int dst_pct);
		route_req_t r;
		route_key_t k;
		int pick;
		int idx;
		r = '0;
		r.net_addr = $urandom();
		r.pfx_len = PLEN_W'($urandom_range(63));
		r.hop_addr = $urandom();
		pick = $urandom_range(99);
		if ($urandom_range(99) < 12) begin
			r.action = action_t'(2'($urandom_range(3)));
		end else if (pick < set_pct) begin
			r.action = ACT_SET;
			if (net_pool.size() != 0 && $urandom_range(1) == 1) begin
				k = net_pool[$urandom_range(net_pool.size() - 1)];
			end else begin
				k.net = $urandom();
				k.plen = ($urandom_range(99) < 3) ? '0 : PLEN_W'($urandom_range(32, 1));
				net_pool.push_back(k);
				if (net_pool.size() > 96) begin
					void'(net_pool.pop_front());
				end
			end
			r = aim_at_route(r, k);
			if ($urandom_range(99) < 60) begin
				r.hop_addr = hop_pool[$urandom_range(7)];
			end
		end else if (pick < set_pct + del_pct) begin
			r.action = ACT_DELETE;
			if (net_pool.size() != 0) begin
				idx = $urandom_range(net_pool.size() - 1);
				r = aim_at_route(r, net_pool[idx]);
				net_pool.delete(idx);
			end
		end else if (pick < set_pct + del_pct + dst_pct) begin
			r.action = ACT_LOOKUP_DST;
			if (net_pool.size() != 0) begin
				r = aim_at_route(r, net_pool[$urandom_range(net_pool.size() - 1)]);
			end
		end else begin
			r.action = ACT_LOOKUP_HOP;
			if ($urandom_range(99) < 80) begin
				r.hop_addr = hop_pool[$urandom_range(7)];
			end
		end
		return r;
	endfunction

	task automatic report_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			steady = beats_in >= 700 && beats_in < 1000;
			if (req.valid && req.ready) begin
				route_table_step(cur_req, model_rsp);
				if (cur_req.typed) begin
					model_rsp.status = cur_req.exp_status;
					model_rsp.found_addr = cur_req.exp_found;
				end
				expected_rsp_q.push_back(model_rsp);
				beats_in++;
			end
			if (!req.valid || req.ready) begin
				if (stim_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					cur_req = stim_q.pop_front();
					req.valid <= 1'b1;
					req.action <= cur_req.action;
					req.net_addr <= cur_req.net_addr;
					req.pfx_len <= cur_req.pfx_len;
					req.hop_addr <= cur_req.hop_addr;
				end else begin
					req.valid <= 1'b0;
				end
			end
			rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_error($sformatf("unexpected response beat: status %0d addr %h",
					rsp.status, rsp.found_addr));
			end else begin
				want_rsp = expected_rsp_q.pop_front();
				if (rsp.status !== want_rsp.status || rsp.found_addr !== want_rsp.found_addr) begin
					report_error($sformatf("expected status %0d addr %h, got status %0d addr %h",
						want_rsp.status, want_rsp.found_addr, rsp.status, rsp.found_addr));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.action = ACT_SET;
		req.net_addr = '0;
		req.pfx_len = '0;
		req.hop_addr = '0;
		rsp.ready = 1'b0;
		for (int k = 0; k < 8; k++) begin
			hop_pool[k] = $urandom();
		end
		for (int k = 0; k < DIR_ROWS; k++) begin
			stim_q.push_back(dir_tab[k]);
		end
		// Fill until the table is full, mix, drain, then mix again.
		repeat (300) stim_q.push_back(random_route_op(80, 5, 10));
		repeat (500) stim_q.push_back(random_route_op(30, 20, 30));
		repeat (300) stim_q.push_back(random_route_op(10, 60, 20));
		repeat (500) stim_q.push_back(random_route_op(35, 15, 30));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || req.valid) begin
			@(posedge clk);
		end
		while (expected_rsp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TABLE_SIZE + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/prtm_pkg.sv
rtl/prtm_req_if.sv
rtl/prtm_rsp_if.sv
rtl/prtm_table_mem.sv
rtl/prtm_ctrl.sv
rtl/prefix_route_table_mtf_top.sv
tb/testbench.sv
